>>> hw/rtl/tclc_pkg.sv
// shared types, constants and codes of the text cell layer compositor
package tclc_pkg;

  // cell store geometry
  localparam int STORE_CELLS = 4096;
  localparam int STORE_AW    = $clog2(STORE_CELLS);
  localparam int SIZE_W      = STORE_AW + 1;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // divider steps, one per quotient bit of the layer index
  localparam int DIV_STEPS = 12;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // transparent character besides zero
  localparam logic [15:0] CHAR_DOLLAR = 16'h0024;

  // command codes of the input item
  localparam logic [1:0] CMD_COMPOSITE = 2'd0;
  localparam logic [1:0] CMD_WRITE     = 2'd1;
  localparam logic [1:0] CMD_READ      = 2'd2;
  localparam logic [1:0] CMD_NONE      = 2'd3;

  // operation kinds after classification
  localparam logic [1:0] OP_COMP  = 2'd0;
  localparam logic [1:0] OP_SKIP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_LAYER_WIDTH  = 3'd0;
  localparam logic [2:0] REG_LAYER_POS_X  = 3'd1;
  localparam logic [2:0] REG_LAYER_POS_Y  = 3'd2;
  localparam logic [2:0] REG_STORE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_STORE_HEIGHT = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] layer_index;
    logic [11:0] cell_x;
    logic [11:0] cell_y;
    logic [15:0] cell_char;
    logic [15:0] cell_attr;
    logic        pass_end;
  } tclc_in_t;

  typedef struct packed {
    logic [15:0] read_char;
    logic [15:0] read_attr;
    logic        in_range;
    logic        cell_changed;
    logic        pass_changed;
  } tclc_out_t;

  // classified operation waiting in the queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pos_a;  // layer index, or column for direct commands
    logic [11:0] pos_b;  // row for direct commands
    logic [15:0] cell_char;
    logic [15:0] cell_attr;
    logic        pass_end;
  } tclc_op_t;

  // register values seen by the back end
  typedef struct packed {
    logic [12:0]        layer_width;
    logic signed [12:0] layer_pos_x;
    logic signed [12:0] layer_pos_y;
    logic [12:0]        store_width;
    logic [SIZE_W-1:0]  valid_size;
  } tclc_cfg_t;

  // back end status toward the front
  typedef struct packed {
    logic clearing;
  } tclc_bk_status_t;

endpackage

>>> hw/rtl/text_cell_layer_compositor.sv
// top level of the text cell layer compositor
//
// Keeps a store of text cells (16-bit character, 16-bit attribute) and
// composites overlay cells into it, or writes and reads cells by x,y.
// Input channel: an item transfers at a clock edge with push high and
// full low. Result channel: the oldest result sits on out_item while empty
// is low and transfers on pop. Every item gives exactly one result.
// Configuration registers sit on an APB-style port at byte addresses 4*i
// and must be written only while the block is idle; the block itself does
// not enforce this. pready is tied high. Items pass a four-entry queue
// into a sequencer that runs one item at a time. A composite item divides
// the layer index by the layer width bit-serially, one quotient bit per
// step, then multiplies, adds, reads the store and writes back; a direct
// write or read does the multiply, add, store read and write-back; a
// transparent cell or unused command goes straight to its result. The
// next queued item starts only after the result of the last one loads.
// After reset the block clears all STORE_CELLS (4096) cells of the store,
// holding full high; register writes are taken during that sweep.
// When the receiver stalls, the finished result waits in the output
// register while the queue keeps taking new items until it fills.
module text_cell_layer_compositor
  import tclc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  tclc_in_t          in_item,
  output logic              empty,
  input  logic              pop,
  output tclc_out_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  tclc_cfg_t       cfg;
  tclc_bk_status_t bk_st;
  tclc_op_t        q_op;
  logic            q_valid;
  logic            q_pop;

  tclc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tclc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .bk_st   (bk_st),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  tclc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .bk_st    (bk_st),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // no item may enter while the store sweep is running
  assert property (@(posedge clk) disable iff (!rst_n) bk_st.clearing |-> full)
    else $error("item could enter during store clear");

  // a changed cell must have been inside the store
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.cell_changed) |-> out_item.in_range)
    else $error("cell change reported outside the store");

  // read data only comes from a cell inside the store
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.read_char != 16'd0 || out_item.read_attr != 16'd0))
      |-> out_item.in_range)
    else $error("read data reported outside the store");

endmodule

>>> hw/rtl/tclc_cfg.sv
// configuration registers behind the APB-style port
module tclc_cfg
  import tclc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output tclc_cfg_t         cfg
);

  logic [12:0]        layer_width_r;
  logic signed [12:0] layer_pos_x_r;
  logic signed [12:0] layer_pos_y_r;
  logic [12:0]        store_width_r;
  logic [12:0]        store_height_r;
  logic [SIZE_W-1:0]  valid_size_r;
  logic [SIZE_W-1:0]  valid_size_nxt;
  logic [25:0]        area;
  logic               wr_en;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_width_r  <= 13'd1;
      layer_pos_x_r  <= '0;
      layer_pos_y_r  <= '0;
      store_width_r  <= 13'd64;
      store_height_r <= 13'd64;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LAYER_WIDTH:  layer_width_r  <= pwdata[12:0];
        REG_LAYER_POS_X:  layer_pos_x_r  <= $signed(pwdata[12:0]);
        REG_LAYER_POS_Y:  layer_pos_y_r  <= $signed(pwdata[12:0]);
        REG_STORE_WIDTH:  store_width_r  <= pwdata[12:0];
        REG_STORE_HEIGHT: store_height_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // register reads, signed fields sign extended
  always_comb begin
    unique case (reg_idx)
      REG_LAYER_WIDTH:  prdata = {19'd0, layer_width_r};
      REG_LAYER_POS_X:  prdata = {{19{layer_pos_x_r[12]}}, layer_pos_x_r};
      REG_LAYER_POS_Y:  prdata = {{19{layer_pos_y_r[12]}}, layer_pos_y_r};
      REG_STORE_WIDTH:  prdata = {19'd0, store_width_r};
      REG_STORE_HEIGHT: prdata = {19'd0, store_height_r};
      default:          prdata = '0;
    endcase
  end

  // usable store size, capped at the store capacity
  assign area = store_width_r * store_height_r;

  always_comb begin
    if (area > 26'(STORE_CELLS)) begin
      valid_size_nxt = SIZE_W'(STORE_CELLS);
    end else begin
      valid_size_nxt = area[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    valid_size_r <= valid_size_nxt;
  end

  assign cfg.layer_width = layer_width_r;
  assign cfg.layer_pos_x = layer_pos_x_r;
  assign cfg.layer_pos_y = layer_pos_y_r;
  assign cfg.store_width = store_width_r;
  assign cfg.valid_size  = valid_size_r;

endmodule

>>> hw/rtl/tclc_front.sv
// input side: accepts items, classifies them and queues them for the back end
module tclc_front
  import tclc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  tclc_in_t        in_item,
  input  tclc_bk_status_t bk_st,
  output logic            q_valid,
  output tclc_op_t        q_op,
  input  logic            q_pop
);

  tclc_op_t            qmem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     cnt_r;
  tclc_op_t            op_new;
  logic                q_full;
  logic                push_ok;
  logic                pop_ok;

  // classify the incoming item
  always_comb begin
    op_new.cell_char = in_item.cell_char;
    op_new.cell_attr = in_item.cell_attr;
    op_new.pos_a     = in_item.cell_x;
    op_new.pos_b     = in_item.cell_y;
    op_new.pass_end  = 1'b0;
    unique case (in_item.cmd)
      CMD_COMPOSITE: begin
        op_new.pos_a    = in_item.layer_index;
        op_new.pass_end = in_item.pass_end;
        if (in_item.cell_char == 16'd0 || in_item.cell_char == CHAR_DOLLAR) begin
          op_new.kind = OP_SKIP;
        end else begin
          op_new.kind = OP_COMP;
        end
      end
      CMD_WRITE: op_new.kind = OP_WRITE;
      CMD_READ:  op_new.kind = OP_READ;
      CMD_NONE:  op_new.kind = OP_SKIP;
    endcase
  end

  // no item is taken while the store is being cleared
  assign q_full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign full    = q_full | bk_st.clearing;
  assign push_ok = push & ~full;
  assign q_valid = (cnt_r != '0);
  assign pop_ok  = q_pop & q_valid;
  assign q_op    = qmem_r[rd_ptr_r];

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      qmem_r[wr_ptr_r] <= op_new;
    end
  end

endmodule

>>> hw/rtl/tclc_div.sv
// restoring divider, one quotient bit per cycle
module tclc_div
  import tclc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [11:0] quot,
  output logic [12:0] rem
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [12:0]       rem_r;
  logic [11:0]       quo_r;
  logic [12:0]       dvs_r;
  logic [13:0]       trial;
  logic [13:0]       diff;
  logic              fits;
  logic              last_step;

  // trial subtract of the shifted partial remainder
  assign trial     = {rem_r, quo_r[11]};
  assign diff      = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});
  assign last_step = (cnt_r == DIV_CW'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last_step) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= fits ? diff[12:0] : trial[12:0];
      quo_r <= {quo_r[10:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

>>> hw/rtl/tclc_back.sv
// back end: address computation, cell store read-modify-write and result register
module tclc_back
  import tclc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  tclc_cfg_t       cfg,
  input  logic            q_valid,
  input  tclc_op_t        q_op,
  output logic            q_pop,
  output tclc_bk_status_t bk_st,
  output logic            empty,
  input  logic            pop,
  output tclc_out_t       out_item
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_WR   = 3'd6;
  localparam logic [2:0] ST_RES  = 3'd7;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [STORE_AW-1:0] clr_cnt_r;
  logic                acc_r;
  logic                out_valid_r;
  tclc_out_t           out_r;

  // working registers of the current operation
  logic [1:0]          kind_r;
  logic [15:0]         char_r;
  logic [15:0]         attr_r;
  logic                pend_r;
  logic signed [13:0]  sx_r;
  logic signed [13:0]  sy_r;
  logic signed [27:0]  prod_r;
  logic [STORE_AW-1:0] addr_r;
  logic                inr_r;
  logic                chg_r;
  logic [31:0]         rd_data_r;

  logic [31:0]         store_mem [STORE_CELLS];
  logic                mem_we;
  logic [STORE_AW-1:0] mem_waddr;
  logic [31:0]         mem_wdata;
  logic [31:0]         new_word;
  logic                writes_cell;

  logic                div_start;
  logic                div_done;
  logic [11:0]         div_quot;
  logic [12:0]         div_rem;
  logic [12:0]         divisor;

  logic signed [28:0]  conv;
  logic signed [27:0]  prod_nxt;
  logic                res_load;
  logic                acc_new;
  tclc_out_t           res;

  assign bk_st.clearing = (state_r == ST_CLR);
  assign q_pop          = (state_r == ST_IDLE) && q_valid;
  assign div_start      = q_pop && (q_op.kind == OP_COMP);
  assign divisor        = (cfg.layer_width == 13'd0) ? 13'd1 : cfg.layer_width;
  assign new_word       = {attr_r, char_r};
  assign writes_cell    = inr_r && (kind_r == OP_COMP || kind_r == OP_WRITE);
  assign res_load       = (state_r == ST_RES) && (!out_valid_r || pop);

  tclc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_op.pos_a),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_cnt_r == STORE_AW'(STORE_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_COMP:  state_nxt = ST_DIV;
            OP_SKIP:  state_nxt = ST_RES;
            OP_WRITE: state_nxt = ST_MUL;
            OP_READ:  state_nxt = ST_MUL;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_RD;
      ST_RD:  state_nxt = ST_WR;
      ST_WR:  state_nxt = ST_RES;
      ST_RES: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // store index: row times store width plus column
  assign prod_nxt = sy_r * $signed({1'b0, cfg.store_width});
  assign conv     = {prod_r[27], prod_r} + {{15{sx_r[13]}}, sx_r};

  // operation datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_op.kind;
      char_r <= q_op.cell_char;
      attr_r <= q_op.cell_attr;
      pend_r <= q_op.pass_end;
      sx_r   <= $signed({2'b00, q_op.pos_a});
      sy_r   <= $signed({2'b00, q_op.pos_b});
      inr_r  <= 1'b0;
      chg_r  <= 1'b0;
    end
    if (state_r == ST_DIV && div_done) begin
      sx_r <= $signed({1'b0, div_rem}) + {cfg.layer_pos_x[12], cfg.layer_pos_x};
      sy_r <= $signed({2'b00, div_quot}) + {cfg.layer_pos_y[12], cfg.layer_pos_y};
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_ADD) begin
      addr_r <= conv[STORE_AW-1:0];
      inr_r  <= !conv[28] && (conv[27:0] < 28'(cfg.valid_size));
    end
    if (state_r == ST_WR) begin
      chg_r <= writes_cell && (rd_data_r != new_word);
    end
  end

  // cell store write port: clearing sweep or the write-back of an operation
  always_comb begin
    if (state_r == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_r == ST_WR) && writes_cell;
      mem_waddr = addr_r;
      mem_wdata = new_word;
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= store_mem[addr_r];
    end
  end

  // result fields and pass accumulator
  always_comb begin
    acc_new = acc_r;
    if (kind_r == OP_COMP || kind_r == OP_SKIP) begin
      acc_new = acc_r | chg_r;
    end
    res.in_range     = inr_r;
    res.cell_changed = chg_r;
    res.pass_changed = acc_new;
    if (kind_r == OP_READ && inr_r) begin
      res.read_char = rd_data_r[15:0];
      res.read_attr = rd_data_r[31:16];
    end else begin
      res.read_char = '0;
      res.read_attr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        acc_r       <= acc_new & ~pend_r;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign empty    = ~out_valid_r;
  assign out_item = out_r;

endmodule
